/* src/sfc_pkg.sv */
// Shared types, constants and helpers of the cross-kernel sharpen filter.
`timescale 1ns / 1ps

package sfc_pkg;

  localparam int PIX_W          = 8;
  localparam int DIM_W          = 11;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int DIM_LIMIT      = 2047;
  localparam int RST_WIDTH      = 640;
  localparam int RST_HEIGHT     = 480;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_e;

  // Per-item decisions handed from the frame control to the datapath.
  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } item_info_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_W'(3)) begin
      r = DIM_W'(3);
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

/* src/sfc_line_buf.sv */
// Two line stores that hold the previous two rows of red samples.
`timescale 1ns / 1ps

module sfc_line_buf
  import sfc_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [COL_W-1:0] wr_addr_i,
  input  logic [PIX_W-1:0] wr_upper_i,
  input  logic [PIX_W-1:0] wr_middle_i,
  output logic [PIX_W-1:0] rd_upper_o,
  output logic [PIX_W-1:0] rd_middle_o
);

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_upper_q;
  logic [PIX_W-1:0] rd_middle_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      upper_mem[wr_addr_i]  <= wr_upper_i;
      middle_mem[wr_addr_i] <= wr_middle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_upper_q  <= upper_mem[rd_addr_i];
      rd_middle_q <= middle_mem[rd_addr_i];
    end
  end

  assign rd_upper_o  = rd_upper_q;
  assign rd_middle_o = rd_middle_q;

endmodule

/* src/sfc_ctrl.sv */
// Configuration registers, frame geometry and raster position counters.
`timescale 1ns / 1ps

module sfc_ctrl
  import sfc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2),
  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [0:0]       cfg_index_i,
  input  logic [DIM_W-1:0] cfg_data_i,
  input  logic             accept_i,
  input  logic             opcode_i,
  input  logic [PIX_W-1:0] red_i,
  output logic             active_o,
  output logic [COL_W-1:0] col_o,
  output logic [PIX_W-1:0] sample_o,
  output item_info_t       info_o
);

  localparam int W_HI  = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;
  localparam int H_HI  = (MAX_HEIGHT < DIM_LIMIT) ? MAX_HEIGHT : DIM_LIMIT;
  localparam int RST_W = (RST_WIDTH > W_HI) ? W_HI : RST_WIDTH;
  localparam int RST_H = (RST_HEIGHT > H_HI) ? H_HI : RST_HEIGHT;
  localparam int RST_T = RST_W * RST_H;

  logic [DIM_W-1:0]   cfg_w_q, cfg_h_q;
  logic [DIM_W-1:0]   act_w_q, act_h_q;
  logic [CNT_W-1:0]   act_total_q;
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic [CNT_W-1:0]   cnt_q;

  logic [DIM_W-1:0]   clamp_w, clamp_h, eff_w, eff_h;
  logic [2*DIM_W-1:0] total_c;
  logic               at_start, in_frame, wrap;
  logic [COL_W:0]     col_inc;
  logic [CNT_W-1:0]   cnt_inc;
  logic [ROW_W-1:0]   eff_h_row;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= DIM_W'(RST_WIDTH);
      cfg_h_q <= DIM_W'(RST_HEIGHT);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  cfg_w_q <= cfg_data_i;
        REG_IMAGE_HEIGHT: cfg_h_q <= cfg_data_i;
        default:          cfg_w_q <= cfg_w_q;
      endcase
    end
  end

  always_comb begin
    clamp_w   = clamp_dim(cfg_w_q, DIM_W'(W_HI));
    clamp_h   = clamp_dim(cfg_h_q, DIM_W'(H_HI));
    total_c   = (2*DIM_W)'(clamp_w) * (2*DIM_W)'(clamp_h);
    at_start  = (row_q == '0) && (col_q == '0) && (cnt_q == '0);
    eff_w     = at_start ? clamp_w : act_w_q;
    eff_h     = at_start ? clamp_h : act_h_q;
    eff_h_row = ROW_W'(eff_h);
    in_frame  = row_q < eff_h_row;
    active_o  = !((opcode_e'(opcode_i) == OP_FLUSH) && in_frame);
    sample_o  = in_frame ? red_i : '0;
    col_o     = col_q;
    col_inc   = {1'b0, col_q} + (COL_W+1)'(1);
    wrap      = col_inc >= (COL_W+1)'(eff_w);
    cnt_inc   = cnt_q + CNT_W'(1);

    info_o.emit   = ((row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0)))
                    && (cnt_q < act_total_q);
    info_o.last   = info_o.emit && (cnt_inc == act_total_q);
    // The first column of a row carries the result of the last column of the row above.
    info_o.border = (col_q == '0) || (col_q == COL_W'(1)) || (row_q == ROW_W'(1))
                    || (row_q == eff_h_row);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_w_q     <= DIM_W'(RST_W);
      act_h_q     <= DIM_W'(RST_H);
      act_total_q <= CNT_W'(RST_T);
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
    end else if (accept_i) begin
      if (at_start) begin
        act_w_q     <= clamp_w;
        act_h_q     <= clamp_h;
        act_total_q <= CNT_W'(total_c);
      end
      if (active_o) begin
        if (info_o.last) begin
          col_q <= '0;
          row_q <= '0;
          cnt_q <= '0;
        end else begin
          if (info_o.emit) begin
            cnt_q <= cnt_inc;
          end
          if (wrap) begin
            col_q <= '0;
            row_q <= row_q + ROW_W'(1);
          end else begin
            col_q <= col_inc[COL_W-1:0];
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < (COL_W+1)'(act_w_q))
    else $error("column counter reached the frame width");

  a_cnt_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < act_total_q)
    else $error("output count reached the frame size");

  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    info_o.last |-> (col_q == '0) && (row_q == ROW_W'(act_h_q) + ROW_W'(1)))
    else $error("frame end at an unexpected raster position");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && active_o && info_o.last |=> (col_q == '0) && (row_q == '0) && (cnt_q == '0))
    else $error("counters not cleared after frame end");
`endif

endmodule

/* src/sfc_kernel.sv */
// 3x3 window registers and the saturating cross-kernel sharpen arithmetic.
`timescale 1ns / 1ps

module sfc_kernel
  import sfc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic [PIX_W-1:0] up_i,
  input  logic [PIX_W-1:0] mid_i,
  input  logic [PIX_W-1:0] sample_i,
  input  logic             border_i,
  output logic [PIX_W-1:0] red_o
);

  // Row-major window, column 2 is the newest column.
  logic [PIX_W-1:0] win_q [9];
  logic [PIX_W-1:0] win_d [9];
  logic signed [PIX_W+3:0] acc;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]     = win_q[r*3 + 1];
      win_d[r*3 + 1] = win_q[r*3 + 2];
    end
    win_d[2] = up_i;
    win_d[5] = mid_i;
    win_d[8] = sample_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

  always_comb begin
    acc = ((PIX_W+4)'(win_d[4]) <<< 2) + (PIX_W+4)'(win_d[4])
          - (PIX_W+4)'(win_d[1]) - (PIX_W+4)'(win_d[7])
          - (PIX_W+4)'(win_d[3]) - (PIX_W+4)'(win_d[5]);
    if (border_i) begin
      red_o = win_d[4];
    end else if (acc < 0) begin
      red_o = '0;
    end else if (acc > (PIX_W+4)'(255)) begin
      red_o = '1;
    end else begin
      red_o = acc[PIX_W-1:0];
    end
  end

endmodule

/* src/sharpen_filter_3x3_cross.sv */
// Top level of the streaming 3x3 cross-kernel sharpen filter on the red channel.
`timescale 1ns / 1ps
// Throughput: one item per clock while the output is not stalled; in_stall_o rises only
// when stage one and the output register are both full and out_stall_i holds. The result
// for a pixel leaves with the item image_width + 1 places later. Reset (async, active low)
// clears counters, window and valid flags and sets geometry to 640 x 480; the line-store
// memories are not cleared and need no clearing pass.

module sharpen_filter_3x3_cross
  import sfc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input stream.
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             opcode_i,
  input  logic [PIX_W-1:0] red_in_i,
  input  logic [PIX_W-1:0] green_in_i,
  input  logic [PIX_W-1:0] blue_in_i,
  // Result stream.
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PIX_W-1:0] red_out_o,
  output logic             frame_last_o,
  // Register write channel.
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [0:0]       cfg_index_i,
  input  logic [DIM_W-1:0] cfg_data_i
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  // The pipeline has two registered stages. At the input transfer the frame control
  // decides everything that depends on the raster position (whether a result leaves,
  // whether it lies on the border, whether it closes the frame) and the line stores
  // start their read. Stage one then holds the item while the read data arrives; when
  // it moves on, the window shifts, the line stores are written back at the same
  // column, and the kernel result is captured in the output register.

  logic             accept;
  logic             active;
  logic [COL_W-1:0] col;
  logic [PIX_W-1:0] sample;
  item_info_t       info;

  logic             s1_valid_q;
  logic [COL_W-1:0] s1_col_q;
  logic [PIX_W-1:0] s1_sample_q;
  item_info_t       s1_info_q;
  logic             s1_fire;

  logic [PIX_W-1:0] rd_upper, rd_middle;
  logic [PIX_W-1:0] result;

  logic             out_valid_q;
  logic [PIX_W-1:0] red_out_q;
  logic             frame_last_q;

  // Stage one moves on whenever the output register is empty or is being emptied,
  // so a waiting result never blocks the item behind it for more than that.
  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign accept     = in_valid_i && !in_stall_o;

  sfc_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .opcode_i    (opcode_i),
    .red_i       (red_in_i),
    .active_o    (active),
    .col_o       (col),
    .sample_o    (sample),
    .info_o      (info)
  );

  // The line stores read at the transfer and write back when stage one moves on. Successive
  // items of a frame differ in column, so a write never meets a pending read of its entry.
  sfc_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i       (clk_i),
    .rd_en_i     (accept),
    .rd_addr_i   (col),
    .wr_en_i     (s1_fire),
    .wr_addr_i   (s1_col_q),
    .wr_upper_i  (rd_middle),
    .wr_middle_i (s1_sample_q),
    .rd_upper_o  (rd_upper),
    .rd_middle_o (rd_middle)
  );

  sfc_kernel u_kernel (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (s1_fire),
    .up_i     (rd_upper),
    .mid_i    (rd_middle),
    .sample_i (s1_sample_q),
    .border_i (s1_info_q.border),
    .red_o    (result)
  );

  // A flush item that arrives while pixels are still expected is taken and dropped
  // here; it never enters stage one and leaves no trace.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= active;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q    <= col;
      s1_sample_q <= sample;
      s1_info_q   <= info;
    end
  end

  // Items early in a frame fill the window without producing a result; they pass
  // through stage one and leave the output register empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= s1_info_q.emit;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      red_out_q    <= result;
      frame_last_q <= s1_info_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = red_out_q;
  assign frame_last_o = frame_last_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled while the pipeline has room");

  a_emit_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q == $past(s1_info_q.emit))
    else $error("output valid does not follow the item that moved on");

  a_last_is_emitted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_info_q.last |-> s1_info_q.emit)
    else $error("frame end marked on an item without a result");
`endif

endmodule

/* dv/tb.sv */
// Self-checking testbench for the streaming 3x3 cross-kernel sharpen filter.
`timescale 1ns / 1ps

module tb;
  import sfc_pkg::*;

  localparam int IDLE_PCT      = 7;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_ITEMS  = 1500;

  // One result of the filter as it should leave the output port.
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic             last;
  } sharp_pixel_t;

  typedef enum int {
    PAT_PEAK,
    PAT_PIT,
    PAT_TEXTURE
  } pattern_e;

  // Tracks the filter's state on every accepted input transfer, queues the pixels
  // that the filter must produce, and checks each output transfer against them.
  class sharpen_scoreboard;
    logic [DIM_W-1:0] reg_width;
    logic [DIM_W-1:0] reg_height;
    int unsigned      frame_w;
    int unsigned      frame_h;
    logic [PIX_W-1:0] upper_line[MAX_WIDTH_DEF];
    logic [PIX_W-1:0] middle_line[MAX_WIDTH_DEF];
    logic [PIX_W-1:0] win[9];
    int unsigned      col;
    int unsigned      row;
    int unsigned      produced;
    sharp_pixel_t     expected_pixels[$];
    int               fails;

    function new();
      reg_width  = DIM_W'(RST_WIDTH);
      reg_height = DIM_W'(RST_HEIGHT);
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col      = 0;
      row      = 0;
      produced = 0;
      fails    = 0;
      frame_w  = bounded_dim(reg_width, MAX_WIDTH_DEF);
      frame_h  = bounded_dim(reg_height, MAX_HEIGHT_DEF);
    endfunction

    function int unsigned bounded_dim(logic [DIM_W-1:0] v, int unsigned max_dim);
      int unsigned hi;
      hi = (max_dim < DIM_LIMIT) ? max_dim : DIM_LIMIT;
      if (v < 3) return 3;
      if (v > hi) return hi;
      return 32'(v);
    endfunction

    function void set_reg(cfg_reg_e idx, logic [DIM_W-1:0] value);
      if (idx == REG_IMAGE_WIDTH) begin
        reg_width = value;
      end else begin
        reg_height = value;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void note_input(opcode_e op, logic [PIX_W-1:0] red);
      logic [PIX_W-1:0] sample;
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] mid;
      int unsigned      out_row;
      int unsigned      out_col;
      int               acc;
      bit               emit;
      sharp_pixel_t     res;
      sample = red;
      // The geometry is taken over at the first item of every frame.
      if (row == 0 && col == 0 && produced == 0) begin
        frame_w = bounded_dim(reg_width, MAX_WIDTH_DEF);
        frame_h = bounded_dim(reg_height, MAX_HEIGHT_DEF);
      end
      if (row < frame_h) begin
        if (op == OP_FLUSH) return;
      end else begin
        sample = '0;
      end
      up  = '0;
      mid = '0;
      if (col < MAX_WIDTH_DEF) begin
        up               = upper_line[col];
        mid              = middle_line[col];
        upper_line[col]  = mid;
        middle_line[col] = sample;
      end
      for (int k = 0; k < 3; k++) begin
        win[k*3]   = win[k*3+1];
        win[k*3+1] = win[k*3+2];
      end
      win[2] = up;
      win[5] = mid;
      win[8] = sample;
      emit = (row >= 2 || (row == 1 && col >= 1)) && produced < frame_w * frame_h;
      if (col >= 1) begin
        out_row = row - 1;
        out_col = col - 1;
      end else begin
        out_row = (row >= 2) ? row - 2 : 0;
        out_col = frame_w - 1;
      end
      col++;
      if (col >= frame_w) begin
        col = 0;
        row++;
      end
      if (!emit) return;
      if (out_row == 0 || out_row == frame_h - 1 || out_col == 0 || out_col == frame_w - 1) begin
        res.red = win[4];
      end else begin
        acc = 5 * int'(win[4]) - int'(win[1]) - int'(win[7]) - int'(win[3]) - int'(win[5]);
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        res.red = PIX_W'(acc);
      end
      produced++;
      res.last = (produced >= frame_w * frame_h);
      if (res.last) begin
        col      = 0;
        row      = 0;
        produced = 0;
      end
      expected_pixels.push_back(res);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      fails++;
    endtask

    task check_result(logic [PIX_W-1:0] red, logic last);
      sharp_pixel_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected result red=%0d last=%0b", red, last));
      end else begin
        want = expected_pixels.pop_front();
        if (red !== want.red) begin
          report($sformatf("red_out got %0d, expected %0d", red, want.red));
        end
        if (last !== want.last) begin
          report($sformatf("frame_last got %0b, expected %0b", last, want.last));
        end
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall_o;
  opcode_e          opcode = OP_PIXEL;
  logic [PIX_W-1:0] red_in = '0;
  logic [PIX_W-1:0] green_in = '0;
  logic [PIX_W-1:0] blue_in = '0;
  logic             out_valid_o;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] red_out_o;
  logic             frame_last_o;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready_o;
  cfg_reg_e         cfg_index = REG_IMAGE_WIDTH;
  logic [DIM_W-1:0] cfg_data = '0;

  sharpen_scoreboard sb;
  // Set during one stretch of the random part so that both sides run flat out.
  bit quiet = 1'b0;
  int frame_items = 0;
  int idle_cycles = 0;

  always #10 clk = ~clk;

  sharpen_filter_3x3_cross u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode),
    .red_in_i    (red_in),
    .green_in_i  (green_in),
    .blue_in_i   (blue_in),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .red_out_o   (red_out_o),
    .frame_last_o(frame_last_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // The receiver holds off output transfers now and then. Outputs are sampled at the
  // clock edge before the nonblocking updates land, so what is read is what the block
  // saw at that edge.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      sb.check_result(red_out_o, frame_last_o);
    end
  end

  // Any transfer on any channel counts as progress; a long stretch without one means
  // the block has hung or lost results.
  always @(posedge clk) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one item and holds it until the block takes it. Valid is left high after
  // the transfer, so a following item without an idle gap goes out back to back.
  task automatic send_item(opcode_e op, logic [PIX_W-1:0] red, logic [PIX_W-1:0] green,
                           logic [PIX_W-1:0] blue);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    red_in   <= red;
    green_in <= green;
    blue_in  <= blue;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    sb.note_input(op, red);
  endtask

  function automatic logic [PIX_W-1:0] pattern_pixel(pattern_e pat, int r, int c);
    bit centre;
    centre = (r == 1 && c == 1);
    case (pat)
      PAT_PEAK: begin
        return centre ? 8'hFF : 8'h00;
      end
      PAT_PIT: begin
        return centre ? 8'h00 : 8'hFF;
      end
      default: begin
        // A share of rail values drives the kernel into both saturation limits.
        if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
        return PIX_W'($urandom_range(255));
      end
    endcase
  endfunction

  // Sends one frame followed by the drain items. With mess_pct of four or more some
  // ignored flush items land in the frame; above zero some drain items are pixel items.
  task automatic send_frame(int w, int h, pattern_e pat, int mess_pct);
    opcode_e op;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        if ($urandom_range(99) < mess_pct / 4) begin
          send_item(OP_FLUSH, PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
                    PIX_W'($urandom_range(255)));
        end
        send_item(OP_PIXEL, pattern_pixel(pat, r, c), PIX_W'($urandom_range(255)),
                  PIX_W'($urandom_range(255)));
      end
    end
    for (int k = 0; k <= w; k++) begin
      op = ($urandom_range(99) < mess_pct) ? OP_PIXEL : OP_FLUSH;
      send_item(op, PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
                PIX_W'($urandom_range(255)));
    end
    frame_items += w * h + w + 1;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [DIM_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // Stops the input stream, lets every pending result arrive, then lets the pipeline
  // settle, since ignored items may still be in flight behind the last one.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers are only rewritten while the block is idle between frames.
  task automatic set_geometry(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [DIM_W-1:0] w_reg;
    logic [DIM_W-1:0] h_reg;
    sb = new();
    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed part: out-of-range geometry clamping to the smallest frame, a single
    // interior pixel pushed into the upper rail and then into the lower rail, and a
    // frame with ignored flushes and pixel items used as drain.
    set_geometry(DIM_W'(2), DIM_W'(0));
    send_frame(3, 3, PAT_PEAK, 0);
    set_geometry(DIM_W'(3), DIM_W'(3));
    send_frame(3, 3, PAT_PIT, 60);

    // Random frames, mostly small. Some frames reuse the geometry and follow the
    // previous one back to back, so the frame turnover is seen under full load.
    frame_items = 0;
    while (frame_items < RANDOM_ITEMS) begin
      quiet = (frame_items >= 500 && frame_items < 850);
      if ($urandom_range(9) < 7) begin
        case ($urandom_range(19))
          0:       w_reg = DIM_W'($urandom_range(0, 2));
          1:       w_reg = DIM_W'($urandom_range(16, 32));
          default: w_reg = DIM_W'($urandom_range(3, 14));
        endcase
        case ($urandom_range(19))
          0:       h_reg = DIM_W'($urandom_range(0, 2));
          1:       h_reg = DIM_W'($urandom_range(9, 16));
          default: h_reg = DIM_W'($urandom_range(3, 8));
        endcase
        set_geometry(w_reg, h_reg);
      end
      send_frame(sb.bounded_dim(sb.reg_width, MAX_WIDTH_DEF),
                 sb.bounded_dim(sb.reg_height, MAX_HEIGHT_DEF),
                 PAT_TEXTURE, $urandom_range(0, 20));
    end
    quiet = 1'b0;

    wait_drained();
    if (sb.fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/sfc_pkg.sv
src/sfc_line_buf.sv
src/sfc_ctrl.sv
src/sfc_kernel.sv
src/sharpen_filter_3x3_cross.sv
dv/tb.sv
